### design/oahm_pkg.sv
// Package for the open addressing hash map.
// Field widths, stream packing and status codes. No dependencies.
package oahm_pkg;

  localparam int KEY_W   = 64;
  localparam int LEN_W   = 4;
  localparam int VAL_W   = 64;
  localparam int SLOT_W  = 10;
  localparam int STAT_W  = 3;
  localparam int USED_W  = 11;
  localparam int LIMIT_W = 10;

  localparam int ENTRY_W = 1 + LEN_W + KEY_W + VAL_W;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 80;

  localparam logic [63:0] DJB2_INIT = 64'd5381;
  localparam logic [LIMIT_W-1:0] FILL_LIMIT_RESET = 10'd614;

  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd2;
  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

endpackage

### design/oahm_ram.sv
// Table memory of the hash map: one write port, one registered read port.
// Uses no package.
module oahm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 133,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/open_addressing_hash_map.sv
// Hash map with open addressing, DJB2 hash and linear downward probing.
// Uses oahm_pkg and oahm_ram.
//
// A request is accepted in S_IDLE and hashed one key byte per step in S_HASH,
// which then takes the home slot. Each probed slot gets a registered table
// read in S_RD, then a compare in S_CHK. S_DONE loads the output register
// once the previous result has been taken, and S_OUT returns to idle; a new
// request is accepted only back in idle. The table memory has one write
// port and one separate read port.
// After reset the block sweeps the whole table to clear the valid bits,
// and no request is accepted during the sweep; fill_limit writes are
// taken at any time.
module open_addressing_hash_map #(
  parameter int TABLE_SIZE = 1024,
  parameter int KEY_BYTES  = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // key_bytes[63:0], key_len[67:64], new_value[131:68], zero fill
  input  logic [oahm_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // req_type[0]
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // found_value[63:0], slot[73:64], zero fill
  output logic [oahm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status[2:0]
  output logic [oahm_pkg::STAT_W-1:0]    m_axis_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [oahm_pkg::LIMIT_W-1:0]   cfg_data
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int CNT_W = IDX_W + 1;
  localparam int KW    = oahm_pkg::KEY_W;
  localparam int LW    = oahm_pkg::LEN_W;
  localparam int VW    = oahm_pkg::VAL_W;
  localparam int EW    = oahm_pkg::ENTRY_W;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HASH  = 7'b0000100,
    S_RD    = 7'b0001000,
    S_CHK   = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t                        state;
  logic [IDX_W-1:0]              clr_idx;
  logic [oahm_pkg::USED_W-1:0]   used_count;
  logic [oahm_pkg::LIMIT_W-1:0]  fill_limit;

  logic                          req_ins;
  logic [KW-1:0]                 key;
  logic [LW-1:0]                 len;
  logic [VW-1:0]                 val;
  logic [LW-1:0]                 bi;
  logic [IDX_W-1:0]              hash;
  logic [IDX_W-1:0]              home;
  logic [IDX_W-1:0]              pos;
  logic [CNT_W-1:0]              cnt;

  logic [VW-1:0]                 res_value;
  logic [oahm_pkg::STAT_W-1:0]   res_status;
  logic [IDX_W-1:0]              res_slot;

  logic                          we;
  logic [IDX_W-1:0]              waddr;
  logic [EW-1:0]                 wdata;
  logic [EW-1:0]                 rdata;

  logic [LW-1:0]                 in_len;
  logic [LW-1:0]                 in_len_c;
  logic [KW-1:0]                 in_key;

  logic                          e_valid;
  logic [LW-1:0]                 e_len;
  logic [KW-1:0]                 e_key;
  logic [VW-1:0]                 e_value;
  logic                          e_hit;
  logic [7:0]                    cur_byte;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);

  assign in_len   = s_axis_tdata[67:64];
  assign in_len_c = (in_len > LW'(KEY_BYTES)) ? LW'(KEY_BYTES) : in_len;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      in_key[i*8 +: 8] = (LW'(i) < in_len_c) ? s_axis_tdata[i*8 +: 8] : 8'd0;
    end
  end

  assign {e_valid, e_len, e_key, e_value} = rdata;
  assign e_hit    = e_valid && (e_len == len) && (e_key == key);
  assign cur_byte = key[bi[2:0]*8 +: 8];

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = {1'b1, len, key, val};
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_idx;
      wdata = '0;
    end else if (state == S_CHK && req_ins == oahm_pkg::REQ_INSERT) begin
      if (e_hit) begin
        we = 1'b1;
      end else if (!e_valid && used_count < oahm_pkg::USED_W'(fill_limit)) begin
        we = 1'b1;
      end
    end
  end

  oahm_ram #(
    .DEPTH (TABLE_SIZE),
    .WIDTH (EW),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (pos),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      used_count    <= '0;
      fill_limit    <= oahm_pkg::FILL_LIMIT_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        fill_limit <= cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IDX_W'(TABLE_SIZE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req_ins <= s_axis_tuser;
            key     <= in_key;
            len     <= in_len_c;
            val     <= s_axis_tdata[131:68];
            bi      <= '0;
            hash    <= IDX_W'(oahm_pkg::DJB2_INIT);
            state   <= S_HASH;
          end
        end
        S_HASH: begin
          if (bi == len) begin
            home  <= hash;
            pos   <= hash;
            cnt   <= '0;
            state <= S_RD;
          end else begin
            hash <= (hash << 5) + hash + IDX_W'(cur_byte);
            bi   <= bi + 1'b1;
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (!e_valid || e_hit || cnt == CNT_W'(TABLE_SIZE - 1)) begin
            res_slot  <= (!e_valid || e_hit) ? pos : home;
            res_value <= (e_hit && req_ins == oahm_pkg::REQ_LOOKUP) ? e_value : '0;
            state     <= S_DONE;
            if (!e_valid) begin
              if (req_ins == oahm_pkg::REQ_LOOKUP) begin
                res_status <= oahm_pkg::ST_NOT_FOUND;
              end else if (used_count < oahm_pkg::USED_W'(fill_limit)) begin
                res_status <= oahm_pkg::ST_INSERTED;
                used_count <= used_count + 1'b1;
              end else begin
                res_status <= oahm_pkg::ST_FULL;
              end
            end else if (e_hit) begin
              res_status <= (req_ins == oahm_pkg::REQ_LOOKUP) ?
                            oahm_pkg::ST_FOUND : oahm_pkg::ST_UPDATED;
            end else begin
              res_status <= (req_ins == oahm_pkg::REQ_LOOKUP) ?
                            oahm_pkg::ST_NOT_FOUND : oahm_pkg::ST_FULL;
            end
          end else begin
            pos   <= pos - 1'b1;
            cnt   <= cnt + 1'b1;
            state <= S_RD;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {6'd0, oahm_pkg::SLOT_W'(res_slot), res_value};
            m_axis_tuser  <= res_status;
            state         <= S_OUT;
          end
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### tb/sv/testbench.sv
// Testbench for open_addressing_hash_map: streams lookups and inserts, predicts
// each answer with a behavioral table and checks every result transfer.
// Depends on oahm_pkg and the open_addressing_hash_map RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL = 1024;
  localparam int CYCLE_LIMIT = 5000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [oahm_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [oahm_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [oahm_pkg::STAT_W-1:0] m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [oahm_pkg::LIMIT_W-1:0] cfg_data = '0;

  typedef struct packed {
    logic [oahm_pkg::VAL_W-1:0] value;
    logic [oahm_pkg::STAT_W-1:0] status;
    logic [oahm_pkg::SLOT_W-1:0] slot;
  } answer_t;

  // predicted table contents
  bit map_valid [TBL];
  logic [oahm_pkg::KEY_W-1:0] map_key [TBL];
  logic [oahm_pkg::LEN_W-1:0] map_len [TBL];
  logic [oahm_pkg::VAL_W-1:0] map_value [TBL];
  int unsigned map_used;
  int unsigned map_limit;

  answer_t pending_answers[$];
  logic [oahm_pkg::KEY_W-1:0] known_keys[$];
  logic [oahm_pkg::LEN_W-1:0] known_lens[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned rx_wait = 0;
  bit hold_off = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  open_addressing_hash_map u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic answer_t hash_map_access(logic op, logic [oahm_pkg::KEY_W-1:0] kb,
                                              logic [oahm_pkg::LEN_W-1:0] kl,
                                              logic [oahm_pkg::VAL_W-1:0] nv);
    answer_t a;
    int unsigned len, home, pos;
    logic [63:0] h, key;
    bit hit, empty;
    len = (kl > 8) ? 8 : kl;
    key = (len == 8) ? kb : kb & ((64'd1 << (8 * len)) - 64'd1);
    h = oahm_pkg::DJB2_INIT;
    for (int i = 0; i < len; i++) h = h * 64'd33 + ((key >> (8 * i)) & 64'hFF);
    home = 32'(h % TBL);
    pos = home;
    hit = 0;
    empty = 0;
    for (int n = 0; n < TBL; n++) begin
      if (!map_valid[pos]) begin
        empty = 1;
        break;
      end
      if (map_len[pos] == len && map_key[pos] == key) begin
        hit = 1;
        break;
      end
      pos = (pos == 0) ? TBL - 1 : pos - 1;
    end
    if (!hit && !empty) pos = home;
    a.value = '0;
    a.slot = pos[oahm_pkg::SLOT_W-1:0];
    if (op == oahm_pkg::REQ_LOOKUP) begin
      if (hit) begin
        a.value = map_value[pos];
        a.status = oahm_pkg::ST_FOUND;
      end else begin
        a.status = oahm_pkg::ST_NOT_FOUND;
      end
    end else if (hit) begin
      map_value[pos] = nv;
      a.status = oahm_pkg::ST_UPDATED;
    end else if (empty && map_used < map_limit) begin
      map_valid[pos] = 1;
      map_key[pos] = key;
      map_len[pos] = oahm_pkg::LEN_W'(len);
      map_value[pos] = nv;
      map_used++;
      a.status = oahm_pkg::ST_INSERTED;
      known_keys.push_back(key);
      known_lens.push_back(oahm_pkg::LEN_W'(len));
    end else begin
      a.status = oahm_pkg::ST_FULL;
    end
    return a;
  endfunction

  task automatic send_request(logic op, logic [oahm_pkg::KEY_W-1:0] kb,
                              logic [oahm_pkg::LEN_W-1:0] kl,
                              logic [oahm_pkg::VAL_W-1:0] nv);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {{(oahm_pkg::IN_DATA_W - 132){1'b0}}, nv, kl, kb};
    do @(posedge clk); while (!s_axis_tready);
    pending_answers.push_back(hash_map_access(op, kb, kl, nv));
  endtask

  // receiver: random wait after each transfer, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst || hold_off) begin
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      rx_wait = $urandom_range(0, 4);
      m_axis_tready <= (rx_wait == 0);
    end else if (rx_wait != 0) begin
      rx_wait = rx_wait - 1;
      m_axis_tready <= (rx_wait == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_answers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer");
      end else begin
        exp_a = pending_answers.pop_front();
        if (m_axis_tdata[63:0] !== exp_a.value || m_axis_tuser !== exp_a.status ||
            m_axis_tdata[73:64] !== exp_a.slot || m_axis_tdata[79:74] !== '0) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp value %h status %0d slot %0d, %s %h status %0d slot %0d",
                     exp_a.value, exp_a.status, exp_a.slot, "got value",
                     m_axis_tdata[63:0], m_axis_tuser, m_axis_tdata[73:64]);
        end
      end
    end
  end

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_fill_limit(int unsigned lim);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= lim[oahm_pkg::LIMIT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    map_limit = lim;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    send_request(oahm_pkg::REQ_LOOKUP, 64'h0, 4'd0, 64'h0);
    send_request(oahm_pkg::REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(oahm_pkg::REQ_LOOKUP, 64'h1234, 4'd0, 64'h0);
    send_request(oahm_pkg::REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h0);
    send_request(oahm_pkg::REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'hA5A5);
    send_request(oahm_pkg::REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 64'h0);
    send_request(oahm_pkg::REQ_INSERT, 64'hDEAD_BEEF_0000_0041, 4'd1, 64'h1);
    send_request(oahm_pkg::REQ_LOOKUP, 64'h0000_0000_0000_0041, 4'd1, 64'hFFFF);
    send_request(oahm_pkg::REQ_INSERT, 64'h41, 4'd2, 64'h2);
    send_request(oahm_pkg::REQ_LOOKUP, 64'h41, 4'd2, 64'h0);
    send_request(oahm_pkg::REQ_LOOKUP, 64'h41, 4'd3, 64'h0);
    for (int i = 0; i < 8; i++)
      send_request(oahm_pkg::REQ_INSERT, rand64(), 4'd1, rand64());
    send_request(oahm_pkg::REQ_LOOKUP, 64'h0, 4'd8, 64'h0);
  endtask

  task automatic test_fill_limit();
    // limit of one, then low limits force table_full and update-at-limit
    write_fill_limit(1);
    send_request(oahm_pkg::REQ_INSERT, rand64(), 4'd8, rand64());
    send_request(oahm_pkg::REQ_INSERT, known_keys[0], known_lens[0], rand64());
    send_request(oahm_pkg::REQ_LOOKUP, known_keys[0], known_lens[0], 64'h0);
    write_fill_limit(map_used + 3);
    for (int i = 0; i < 6; i++)
      send_request(oahm_pkg::REQ_INSERT, rand64(), 4'($urandom_range(1, 8)), rand64());
  endtask

  task automatic random_mix(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 9);
      if (k < 4 && known_keys.size() > 0) begin
        int j;
        j = $urandom_range(0, known_keys.size() - 1);
        send_request(1'($urandom_range(0, 1)),
                     known_keys[j] | (rand64() << (8 * known_lens[j]))
                     & ((known_lens[j] >= 8) ? 64'h0 : 64'hFFFF_FFFF_FFFF_FFFF),
                     ($urandom_range(0, 5) == 0 && known_lens[j] == 8) ?
                     4'($urandom_range(8, 15)) : known_lens[j], rand64());
      end else if (k < 6) begin
        // short keys collide and build probe chains
        send_request(1'($urandom_range(0, 1)), {56'h0, 8'($urandom_range(0, 255))},
                     4'($urandom_range(0, 2)), rand64());
      end else begin
        send_request(1'($urandom_range(0, 1)), rand64(), 4'($urandom_range(0, 15)),
                     rand64());
      end
    end
  endtask

  task automatic test_random_traffic();
    write_fill_limit(614);
    random_mix(200);
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        random_mix(40);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    join
  endtask

  task automatic test_full_table();
    write_fill_limit(1023);
    random_mix(280);
  endtask

  initial begin
    for (int i = 0; i < TBL; i++) map_valid[i] = 0;
    map_used = 0;
    map_limit = oahm_pkg::FILL_LIMIT_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_limit();
    test_random_traffic();
    test_backpressure();
    test_full_table();
    wait_drained();
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

### files.f
design/oahm_pkg.sv
design/oahm_ram.sv
design/open_addressing_hash_map.sv
tb/sv/testbench.sv
